// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 32;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic                valid;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		cell_op_t            op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} cell_cmd_t;

endpackage

// File: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry, compares it with the broadcast key and
// takes its neighbor's entry, the new entry, or keeps its own.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_cmd_t cmd,
	input  spq_pkg::entry_t    prev_ent,
	input  logic               prev_place,
	input  spq_pkg::entry_t    next_ent,
	output spq_pkg::entry_t    ent,
	output logic               place
);

	logic                         valid_q;
	logic [spq_pkg::KEY_W-1:0]    key_q;
	logic [spq_pkg::HANDLE_W-1:0] handle_q;

	assign ent   = '{valid: valid_q, key: key_q, handle: handle_q};
	// new key goes here or earlier
	assign place = !valid_q || ($signed(cmd.key) < $signed(key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				spq_pkg::OP_INSERT: begin
					if (prev_place) begin
						valid_q <= prev_ent.valid;
					end else if (place) begin
						valid_q <= 1'b1;
					end
				end
				spq_pkg::OP_REMOVE: valid_q <= next_ent.valid;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			spq_pkg::OP_INSERT: begin
				if (prev_place) begin
					key_q    <= prev_ent.key;
					handle_q <= prev_ent.handle;
				end else if (place) begin
					key_q    <= cmd.key;
					handle_q <= cmd.handle;
				end
			end
			spq_pkg::OP_REMOVE: begin
				key_q    <= next_ent.key;
				handle_q <= next_ent.handle;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue in ascending signed key order, built as a row of
// compare-and-shift cells.
// ----------------------------------------------------------------------------
// Takes one insert or remove per clock while the input is ready: every cell
// compares the broadcast key in parallel and shifts toward its neighbor, and
// the result of each transfer is loaded into the output register as the cells
// update. The input is ready whenever the output register is empty or is being
// drained in the same cycle. Equal keys leave in arrival order. CAPACITY sets
// the number of cells; an insert into a full queue is refused with a full
// status and a remove from an empty queue reports empty. The queue is empty
// right after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // item_handle[31:0], sort_key[63:32]
	input  logic        s_tuser,  // kind[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // status[1:0], removed_handle[33:2],
	                              // removed_key[65:34], now_empty[66], zero
);

	spq_pkg::entry_t    ent_w   [CAPACITY];
	logic               place_w [CAPACITY];
	logic [CAPACITY-1:0] valid_w;
	spq_pkg::cell_cmd_t cmd;

	logic                         accept;
	logic                         full;
	logic                         empty;
	spq_pkg::kind_t               kind;
	spq_pkg::status_t             status_d;
	logic [spq_pkg::HANDLE_W-1:0] rm_handle_d;
	logic [spq_pkg::KEY_W-1:0]    rm_key_d;
	logic                         now_empty_d;

	logic                         out_valid_q;
	spq_pkg::status_t             status_q;
	logic [spq_pkg::HANDLE_W-1:0] rm_handle_q;
	logic [spq_pkg::KEY_W-1:0]    rm_key_q;
	logic                         now_empty_q;

	assign kind     = spq_pkg::kind_t'(s_tuser);
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = ent_w[CAPACITY-1].valid;
	assign empty    = !ent_w[0].valid;

	always_comb begin
		cmd.key     = s_tdata[63:32];
		cmd.handle  = s_tdata[31:0];
		cmd.op      = spq_pkg::OP_HOLD;
		status_d    = spq_pkg::ST_OK;
		rm_handle_d = '0;
		rm_key_d    = '0;
		now_empty_d = empty;
		if (kind == spq_pkg::KIND_INSERT) begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				if (accept) cmd.op = spq_pkg::OP_INSERT;
				now_empty_d = 1'b0;
			end
		end else begin
			if (empty) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				if (accept) cmd.op = spq_pkg::OP_REMOVE;
				rm_handle_d = ent_w[0].handle;
				rm_key_d    = ent_w[0].key;
				now_empty_d = !ent_w[1].valid;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::entry_t prev_ent;
		spq_pkg::entry_t next_ent;
		logic            prev_place;

		if (i == 0) begin : g_first
			assign prev_ent   = '0;
			assign prev_place = 1'b0;
		end else begin : g_mid
			assign prev_ent   = ent_w[i-1];
			assign prev_place = place_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_ent = '0;
		end else begin : g_body
			assign next_ent = ent_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_ent   (prev_ent),
			.prev_place (prev_place),
			.next_ent   (next_ent),
			.ent        (ent_w[i]),
			.place      (place_w[i])
		);

		assign valid_w[i] = ent_w[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			rm_handle_q <= rm_handle_d;
			rm_key_q    <= rm_key_d;
			now_empty_q <= now_empty_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, now_empty_q, rm_key_q, rm_handle_q, status_q};

	// occupancy is always a prefix of ones
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_w & (valid_w + 1'b1)) == '0)
		else $error("cell occupancy is not a prefix");

	// an accepted insert that is not refused leaves the queue non-empty
	a_insert_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == spq_pkg::KIND_INSERT && !full) |=> ent_w[0].valid)
		else $error("insert did not occupy head cell");

	// an empty report carries no entry and an empty queue
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == spq_pkg::ST_EMPTY) |->
		(rm_handle_q == '0 && rm_key_q == '0 && now_empty_q))
		else $error("empty result carries data");

	// now_empty in a result matches the head cell after the transfer
	a_now_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (now_empty_q == !ent_w[0].valid))
		else $error("now_empty disagrees with head cell");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue core.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own sorted copy of the queue. Every accepted input
// transfer updates that copy and queues the result it must produce. Results
// are then checked field by field in order. A short directed run covers the
// key extremes, equal keys, removal from an empty queue and insertion into a
// full queue. Random phases follow, each with its own mix of inserts and
// removes and its own key range. Both stream sides pause at random, and some
// phases run without any pauses.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 16;
	localparam int RAND_ITEMS  = 1600;
	localparam int PHASE_LEN   = 80;
	localparam int CYCLE_LIMIT = 1000000;

	class spq_scoreboard;
		typedef struct {
			logic signed [spq_pkg::KEY_W-1:0] key;
			logic [spq_pkg::HANDLE_W-1:0]     handle;
		} slot_t;

		typedef struct {
			spq_pkg::status_t                 status;
			logic [spq_pkg::HANDLE_W-1:0]     handle;
			logic signed [spq_pkg::KEY_W-1:0] key;
			logic                             now_empty;
		} outcome_t;

		int       capacity;
		slot_t    slots[$];
		outcome_t pending_results[$];
		int       mismatches;
		int       n_insert;
		int       n_remove;
		int       n_full;
		int       n_empty;

		function new(int cap);
			capacity   = cap;
			mismatches = 0;
			n_insert   = 0;
			n_remove   = 0;
			n_full     = 0;
			n_empty    = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void predict_transfer(spq_pkg::kind_t kind,
		                               logic [spq_pkg::HANDLE_W-1:0] handle,
		                               logic signed [spq_pkg::KEY_W-1:0] key);
			outcome_t r;
			slot_t    s;
			int       pos;
			r.status    = spq_pkg::ST_OK;
			r.handle    = '0;
			r.key       = '0;
			if (kind == spq_pkg::KIND_INSERT) begin
				n_insert++;
				if (slots.size() >= capacity) begin
					r.status = spq_pkg::ST_FULL;
					n_full++;
				end else begin
					pos = 0;
					while (pos < slots.size() && !(key < slots[pos].key))
						pos++;
					s.key    = key;
					s.handle = handle;
					slots.insert(pos, s);
				end
			end else begin
				n_remove++;
				if (slots.size() == 0) begin
					r.status = spq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					r.handle = slots[0].handle;
					r.key    = slots[0].key;
					void'(slots.pop_front());
				end
			end
			r.now_empty = (slots.size() == 0);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [71:0] data);
			outcome_t r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, data);
				mismatches++;
				return;
			end
			r = pending_results.pop_front();
			if (data[1:0] !== r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, r.status, data[1:0]);
				mismatches++;
			end
			if (data[33:2] !== r.handle) begin
				$display("%0t: removed_handle expected %h actual %h", $time, r.handle,
				         data[33:2]);
				mismatches++;
			end
			if (data[65:34] !== r.key) begin
				$display("%0t: removed_key expected %h actual %h", $time, r.key, data[65:34]);
				mismatches++;
			end
			if (data[66] !== r.now_empty) begin
				$display("%0t: now_empty expected %b actual %b", $time, r.now_empty, data[66]);
				mismatches++;
			end
			if (data[71:67] !== 5'b0) begin
				$display("%0t: padding expected 00 actual %h", $time, data[71:67]);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // item_handle[31:0], sort_key[63:32]
	logic        s_tuser;   // kind[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // status[1:0], removed_handle[33:2], removed_key[65:34],
	                        // now_empty[66], zero

	bit            calm_phase;
	int            cycle_count;
	spq_scoreboard sb = new(DEPTH);

	sorted_priority_queue_core #(.CAPACITY(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			         sb.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	// mostly no pause, sometimes short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_phase || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [spq_pkg::KEY_W-1:0] pick_key(int mode);
		logic signed [spq_pkg::KEY_W-1:0] corners[6];
		corners = '{32'sh8000_0000, 32'sh8000_0001, 32'sh7fff_ffff, 32'sh7fff_fffe,
		            32'sh0, -32'sh1};
		case (mode)
			0: return $signed($urandom_range(0, 7)) - 4;
			1: return $urandom;
			default: return corners[$urandom_range(0, 5)];
		endcase
	endfunction

	task automatic send_item(spq_pkg::kind_t kind, logic [spq_pkg::HANDLE_W-1:0] handle,
	                         logic signed [spq_pkg::KEY_W-1:0] key);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {key, handle};
		do @(posedge clk); while (!s_tready);
		sb.predict_transfer(kind, handle, key);
	endtask

	// result side with random stalls
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		int ins_pct;
		int key_mode;
		calm_phase  = 1'b0;
		cycle_count = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= spq_pkg::KIND_INSERT;
		s_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty remove, extremes, equal keys, fill up, full refusal
		send_item(spq_pkg::KIND_REMOVE, 32'hffff_ffff, 32'sh7fff_ffff);
		send_item(spq_pkg::KIND_INSERT, 32'hffff_ffff, 32'sh7fff_ffff);
		send_item(spq_pkg::KIND_INSERT, 32'h0, 32'sh8000_0000);
		send_item(spq_pkg::KIND_INSERT, 32'h1234_5678, 32'sh0);
		send_item(spq_pkg::KIND_INSERT, 32'hdead_beef, -32'sh1);
		send_item(spq_pkg::KIND_INSERT, 32'h0000_0001, 32'sh5);
		send_item(spq_pkg::KIND_INSERT, 32'h0000_0002, 32'sh5);
		for (int i = 0; i < 10; i++)
			send_item(spq_pkg::KIND_INSERT, $urandom, (i % 3 == 0) ? 32'sh5 : pick_key(1));
		send_item(spq_pkg::KIND_INSERT, 32'haaaa_5555, 32'sh1);
		for (int i = 0; i < 6; i++)
			send_item(spq_pkg::KIND_REMOVE, $urandom, pick_key(1));

		// random phases with their own insert mix and key range
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % PHASE_LEN == 0) begin
				case ($urandom_range(0, 3))
					0: ins_pct = 90;
					1: ins_pct = 10;
					default: ins_pct = 55;
				endcase
				key_mode   = $urandom_range(0, 2);
				calm_phase = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < ins_pct)
				send_item(spq_pkg::KIND_INSERT, $urandom, pick_key(key_mode));
			else
				send_item(spq_pkg::KIND_REMOVE, $urandom, pick_key(1));
		end
		s_tvalid <= 1'b0;
		calm_phase = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d inserts (%0d refused as full) and %0d removes (%0d on an empty queue)",
		         sb.n_insert, sb.n_full, sb.n_remove, sb.n_empty);
		$display("%0d field mismatches over %0d cycles", sb.mismatches, cycle_count);
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
tb/sv/testbench.sv
